/* hw/rtl/rtc_pkg.sv */
// Shared types, constants and helpers of the route transposition cipher.
`default_nettype none

package rtc_pkg;

  localparam int MAX_DIM_DEF = 8;    // default grid side
  localparam int REG_W       = 4;    // width of the dimension and route registers
  localparam int CHAR_W      = 8;
  localparam int FILL_W      = 7;    // fill count as carried between front and back
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 4;
  localparam int BANKS       = 2;    // grid banks: one loading, one emitting
  localparam int CMD_DEPTH   = 2;
  localparam int OUT_DEPTH   = 4;

  localparam logic [CHAR_W-1:0] PAD_ENC = 8'h58;  // 'X'
  localparam logic [CHAR_W-1:0] PAD_DEC = 8'h2E;  // '.'
  localparam logic [CHAR_W-1:0] LOW_A   = 8'h61;
  localparam logic [CHAR_W-1:0] LOW_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] UP_A    = 8'h41;
  localparam logic [CHAR_W-1:0] UP_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    REG_DIRECTION = 2'd0,
    REG_ROW_COUNT = 2'd1,
    REG_COL_COUNT = 2'd2,
    REG_ROUTE     = 2'd3
  } reg_idx_t;

  typedef enum logic {
    DIR_ENCRYPT = 1'b0,
    DIR_DECRYPT = 1'b1
  } dir_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

  typedef struct packed {
    dir_t             direction;
    logic [REG_W-1:0] row_count;
    logic [REG_W-1:0] col_count;
    logic [REG_W-1:0] route;
  } cfg_t;

  // One grid ready for emission.
  typedef struct packed {
    logic              bank;
    cfg_t              cfg;
    logic [FILL_W-1:0] fill;
    logic              ovf;
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              dropped;
  } out_item_t;

  // Map a dimension register onto 1..max_dim.
  function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v,
                                                 input logic [REG_W-1:0] max_dim);
    logic [REG_W-1:0] res;
    res = v;
    if (v == '0) res = REG_W'(1);
    else if (v > max_dim) res = max_dim;
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rtc_fifo.sv */
// Small register-based first-in first-out queue.
`default_nettype none

module rtc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            empty,
  output logic                            full,
  output logic      [$clog2(DEPTH):0]     count
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W:0]   rd_ptr_r, rd_ptr_nxt;
  logic             do_push, do_pop;

  assign count   = wr_ptr_r - rd_ptr_r;
  assign empty   = (count == '0);
  assign full    = (count == (PTR_W+1)'(DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = slot_r[rd_ptr_r[PTR_W-1:0]];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r[PTR_W-1:0]] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rtc_front.sv */
// Load side: filters message bytes, fills the grid bank and issues emit commands.
`default_nettype none

module rtc_front #(
  parameter int MAX_DIM = rtc_pkg::MAX_DIM_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rtc_pkg::cfg_t                 cfg,
  input  wire logic                          push,
  input  wire logic [rtc_pkg::CHAR_W-1:0]    char_in,
  input  wire logic                          has_char,
  input  wire logic                          end_of_message,
  output logic                               full,
  output logic                               mem_we,
  output logic [$clog2(MAX_DIM*MAX_DIM):0]   mem_waddr,
  output logic [rtc_pkg::CHAR_W-1:0]         mem_wdata,
  output logic                               cmd_push,
  output rtc_pkg::cmd_t                      cmd,
  input  wire logic                          done
);

  localparam int CELLS  = MAX_DIM * MAX_DIM;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CELL_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int OUT_W  = $clog2(rtc_pkg::BANKS + 1);

  logic [CNT_W-1:0]           fill_r, fill_nxt, fill_inc;
  logic                       ovf_r, ovf_nxt, ovf_inc;
  logic                       bank_r, bank_nxt;
  logic [OUT_W-1:0]           pend_r, pend_nxt;
  logic                       accept, keep, room, store;
  logic [rtc_pkg::CHAR_W-1:0] ch_up;
  logic [rtc_pkg::REG_W-1:0]  rows_c, cols_c;
  logic [2*DIM_W-1:0]         rows_x, cols_x, cap_full;
  logic [CNT_W-1:0]           cap;

  assign full   = (pend_r == OUT_W'(rtc_pkg::BANKS));
  assign accept = push & ~full;

  // Uppercase and filter letters in encrypt mode; decrypt keeps every byte.
  always_comb begin
    ch_up = char_in;
    if (cfg.direction == rtc_pkg::DIR_ENCRYPT &&
        char_in >= rtc_pkg::LOW_A && char_in <= rtc_pkg::LOW_Z) begin
      ch_up = char_in - rtc_pkg::CASE_OFS;
    end
    keep = (cfg.direction == rtc_pkg::DIR_DECRYPT) ||
           (ch_up >= rtc_pkg::UP_A && ch_up <= rtc_pkg::UP_Z);
  end

  assign rows_c   = rtc_pkg::clamp_dim(cfg.row_count, rtc_pkg::REG_W'(MAX_DIM));
  assign cols_c   = rtc_pkg::clamp_dim(cfg.col_count, rtc_pkg::REG_W'(MAX_DIM));
  assign rows_x   = (2*DIM_W)'(rows_c[DIM_W-1:0]);
  assign cols_x   = (2*DIM_W)'(cols_c[DIM_W-1:0]);
  assign cap_full = rows_x * cols_x;
  assign cap      = cap_full[CNT_W-1:0];
  assign room     = (fill_r < cap);
  assign store    = accept & has_char & keep & room;

  assign mem_we    = store;
  assign mem_waddr = {bank_r, fill_r[CELL_W-1:0]};
  assign mem_wdata = ch_up;

  // Count and flag including this item's byte, as seen by the emit command.
  assign fill_inc = store ? fill_r + 1'b1 : fill_r;
  assign ovf_inc  = ovf_r | (accept & has_char & keep & ~room);

  assign cmd_push      = accept & end_of_message;
  assign cmd.bank      = bank_r;
  assign cmd.cfg       = cfg;
  assign cmd.fill      = rtc_pkg::FILL_W'(fill_inc);
  assign cmd.ovf       = ovf_inc;

  always_comb begin
    fill_nxt = fill_inc;
    ovf_nxt  = ovf_inc;
    bank_nxt = bank_r;
    if (cmd_push) begin
      fill_nxt = '0;
      ovf_nxt  = 1'b0;
      bank_nxt = ~bank_r;
    end
    case ({cmd_push, done})
      2'b10:   pend_nxt = pend_r + 1'b1;
      2'b01:   pend_nxt = pend_r - 1'b1;
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
      pend_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      ovf_r  <= ovf_nxt;
      bank_r <= bank_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rtc_back.sv */
// Emit side: grid memory and the route walker that reads one cell per cycle while the result queue has room.
`default_nettype none

module rtc_back #(
  parameter int MAX_DIM   = rtc_pkg::MAX_DIM_DEF,
  parameter int OUT_DEPTH = rtc_pkg::OUT_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cmd_empty,
  input  wire rtc_pkg::cmd_t                     cmd,
  output logic                                   cmd_pop,
  input  wire logic                              mem_we,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM):0]  mem_waddr,
  input  wire logic [rtc_pkg::CHAR_W-1:0]        mem_wdata,
  input  wire logic [$clog2(OUT_DEPTH):0]        out_count,
  output logic                                   out_push,
  output rtc_pkg::out_item_t                     out_item,
  output logic                                   done
);

  localparam int CELLS     = MAX_DIM * MAX_DIM;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int CELL_W    = $clog2(CELLS);
  localparam int CNT_W     = $clog2(CELLS + 1);
  localparam int MEM_DEPTH = 2 * (2 ** CELL_W);
  localparam int OC_W      = $clog2(OUT_DEPTH) + 1;
  localparam int PROD_W    = IDX_W + DIM_W;

  logic [rtc_pkg::CHAR_W-1:0] grid_mem_r [MEM_DEPTH];

  rtc_pkg::back_state_t state_r, state_nxt;

  // Per-grid settings, latched when a command is taken.
  logic                 bank_r, dec_r, fr_r, fb_r, bycols_r, serp_r, ovf_r;
  logic [DIM_W-1:0]     rows_r, cols_r;
  logic [IDX_W-1:0]     rm1_r, cm1_r, outer_m1_r, inner_m1_r;
  logic [CNT_W-1:0]     fill_r;
  logic [IDX_W-1:0]     i_r, j_r, i_nxt, j_nxt;

  // Read stage.
  logic                       rd_valid_r;
  logic [rtc_pkg::CHAR_W-1:0] rd_data_r, padc_r;
  logic                       pad_r, last_r, drop_r;

  logic                      credit, issue, last_cell;
  logic [rtc_pkg::REG_W-1:0] rows_c, cols_c;
  logic [DIM_W-1:0]          rows_d, cols_d;
  logic [IDX_W-1:0]          rm1_c, cm1_c, llm1;
  logic [IDX_W-1:0]          e_p, e_row, e_col, d_line, d_p0, d_p;
  logic [IDX_W-1:0]          hi, lo;
  logic [DIM_W-1:0]          mult;
  logic [PROD_W-1:0]         prod;
  logic [CELL_W-1:0]         addr;

  // Leave room in the result queue for the read already in flight.
  assign credit    = ({1'b0, out_count} + (OC_W+1)'(rd_valid_r)) < (OC_W+1)'(OUT_DEPTH);
  assign last_cell = (i_r == outer_m1_r) && (j_r == inner_m1_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtc_pkg::BK_IDLE: if (!cmd_empty) state_nxt = rtc_pkg::BK_RUN;
      rtc_pkg::BK_RUN:  if (credit && last_cell) state_nxt = rtc_pkg::BK_IDLE;
      default:          state_nxt = rtc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    issue   = 1'b0;
    unique case (state_r)
      rtc_pkg::BK_IDLE: cmd_pop = ~cmd_empty;
      rtc_pkg::BK_RUN:  issue   = credit;
      default: begin
        cmd_pop = 1'b0;
        issue   = 1'b0;
      end
    endcase
  end

  assign done = issue & last_cell;

  // Decode the command's geometry.
  assign rows_c = rtc_pkg::clamp_dim(cmd.cfg.row_count, rtc_pkg::REG_W'(MAX_DIM));
  assign cols_c = rtc_pkg::clamp_dim(cmd.cfg.col_count, rtc_pkg::REG_W'(MAX_DIM));
  assign rows_d = rows_c[DIM_W-1:0];
  assign cols_d = cols_c[DIM_W-1:0];
  assign rm1_c  = IDX_W'(rows_d - 1'b1);
  assign cm1_c  = IDX_W'(cols_d - 1'b1);

  // Cell address of the current step. Encrypt walks the route and reads the
  // cell it lands on; decrypt walks rows and reads the byte whose route step
  // lands here.
  always_comb begin
    llm1 = bycols_r ? rm1_r : cm1_r;

    e_p = (serp_r && i_r[0]) ? llm1 - j_r : j_r;
    if (bycols_r) begin
      e_row = fb_r ? rm1_r - e_p : e_p;
      e_col = fr_r ? cm1_r - i_r : i_r;
    end else begin
      e_row = fb_r ? rm1_r - i_r : i_r;
      e_col = fr_r ? cm1_r - e_p : e_p;
    end

    if (bycols_r) begin
      d_line = fr_r ? cm1_r - j_r : j_r;
      d_p0   = fb_r ? rm1_r - i_r : i_r;
    end else begin
      d_line = fb_r ? rm1_r - i_r : i_r;
      d_p0   = fr_r ? cm1_r - j_r : j_r;
    end
    d_p = (serp_r && d_line[0]) ? llm1 - d_p0 : d_p0;

    if (dec_r) begin
      hi   = d_line;
      lo   = d_p;
      mult = bycols_r ? rows_r : cols_r;
    end else begin
      hi   = e_row;
      lo   = e_col;
      mult = cols_r;
    end
  end

  assign prod = PROD_W'(hi) * PROD_W'(mult) + PROD_W'(lo);
  assign addr = prod[CELL_W-1:0];

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (cmd_pop) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if (issue) begin
      if (j_r == inner_m1_r) begin
        j_nxt = '0;
        i_nxt = i_r + 1'b1;
      end else begin
        j_nxt = j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rtc_pkg::BK_IDLE;
      rd_valid_r <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= issue;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
    end
  end

  // Latch the grid settings.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      bank_r   <= cmd.bank;
      dec_r    <= (cmd.cfg.direction == rtc_pkg::DIR_DECRYPT);
      fb_r     <= cmd.cfg.route[3];
      fr_r     <= cmd.cfg.route[3] ^ cmd.cfg.route[2];
      bycols_r <= cmd.cfg.route[1];
      serp_r   <= cmd.cfg.route[0];
      rows_r   <= rows_d;
      cols_r   <= cols_d;
      rm1_r    <= rm1_c;
      cm1_r    <= cm1_c;
      fill_r   <= cmd.fill[CNT_W-1:0];
      ovf_r    <= cmd.ovf;
      if (cmd.cfg.direction == rtc_pkg::DIR_ENCRYPT && cmd.cfg.route[1]) begin
        outer_m1_r <= cm1_c;
        inner_m1_r <= rm1_c;
      end else begin
        outer_m1_r <= rm1_c;
        inner_m1_r <= cm1_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= grid_mem_r[{bank_r, addr}];
      pad_r     <= !(CNT_W'(addr) < fill_r);
      padc_r    <= dec_r ? rtc_pkg::PAD_DEC : rtc_pkg::PAD_ENC;
      last_r    <= last_cell;
      drop_r    <= ovf_r;
    end
  end

  assign out_push         = rd_valid_r;
  assign out_item.ch      = pad_r ? padc_r : rd_data_r;
  assign out_item.last    = last_r;
  assign out_item.dropped = drop_r;

`ifndef SYNTHESIS
  // The bank being emitted is never the bank being loaded.
  a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && mem_we) |-> (mem_waddr[CELL_W] != bank_r))
    else $error("grid write hit the bank under emission");

  // A read is only issued with room left in the result queue.
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> ({1'b0, out_count} < (OC_W+1)'(OUT_DEPTH)))
    else $error("read issued without result queue space");
`endif

endmodule

`default_nettype wire

/* hw/rtl/route_transposition_cipher.sv */
// Top level of the route transposition cipher: config registers and block wiring.
`default_nettype none

// Route transposition cipher. Bytes pushed on the in_ side load one message
// into a grid of row_count x col_count cells (at most MAX_DIM x MAX_DIM), one
// beat per cycle while full is low, each byte written straight into the grid
// memory. An item with end_of_message set (with or without a byte) closes the
// message; the grid is then emitted on the out_ side, row_count*col_count beats,
// one cell per cycle as long as pop keeps up, with out_last_out on the final
// beat. The emission rate is set by the single read port of the grid memory.
// With the emitter free, the first result shows on the out_ ports after
// passing through the command queue, the settings latch, the read stage and
// the result queue. Encrypt mode keeps letters only, uppercases them, fills
// row by row, pads with 'X' and emits along the selected route; decrypt mode
// places raw bytes along the route, pads with '.' and emits row by row. Bytes
// beyond the grid are dropped and reported on out_dropped for every beat of
// that grid. The grid memory has two banks, so the next message loads while
// the previous one is still being emitted; full rises only while one grid is
// still being emitted and a second closed grid waits behind it. Program
// the registers (direction, row_count, col_count, route at byte addresses 0,
// 4, 8, 12) only while the block is idle.
module route_transposition_cipher #(
  parameter int MAX_DIM = rtc_pkg::MAX_DIM_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rtc_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [rtc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [rtc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  // message input
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [rtc_pkg::CHAR_W-1:0]        in_char_in,
  input  wire logic                              in_has_char,
  input  wire logic                              in_end_of_message,
  // grid output
  output logic                                   empty,
  input  wire logic                              pop,
  output logic      [rtc_pkg::CHAR_W-1:0]        out_char_out,
  output logic                                   out_last_out,
  output logic                                   out_dropped
);

  localparam int CELL_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int CMD_W  = $bits(rtc_pkg::cmd_t);
  localparam int ITEM_W = $bits(rtc_pkg::out_item_t);

  rtc_pkg::cfg_t       cfg_r, cfg_nxt;
  rtc_pkg::reg_idx_t   reg_idx;
  logic                cfg_wr;

  logic                        mem_we;
  logic [CELL_W:0]             mem_waddr;
  logic [rtc_pkg::CHAR_W-1:0]  mem_wdata;
  logic                        cmd_push, cmd_pop, cmd_empty, cmd_full;
  logic [$clog2(rtc_pkg::CMD_DEPTH):0] cmd_count;
  rtc_pkg::cmd_t               cmd_in, cmd_out;
  logic [CMD_W-1:0]            cmd_out_bits;
  logic                        done;
  logic                        out_push, out_full;
  logic [$clog2(rtc_pkg::OUT_DEPTH):0] out_count;
  rtc_pkg::out_item_t          item_in, item_out;
  logic [ITEM_W-1:0]           item_out_bits;

  // Register port: writes land in the access phase, no wait states.
  assign pready  = 1'b1;
  assign reg_idx = rtc_pkg::reg_idx_t'(paddr[rtc_pkg::APB_ADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        rtc_pkg::REG_DIRECTION: cfg_nxt.direction = rtc_pkg::dir_t'(pwdata[0]);
        rtc_pkg::REG_ROW_COUNT: cfg_nxt.row_count = pwdata[rtc_pkg::REG_W-1:0];
        rtc_pkg::REG_COL_COUNT: cfg_nxt.col_count = pwdata[rtc_pkg::REG_W-1:0];
        rtc_pkg::REG_ROUTE:     cfg_nxt.route     = pwdata[rtc_pkg::REG_W-1:0];
        default:                cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rtc_pkg::REG_DIRECTION: prdata = rtc_pkg::APB_DATA_W'(cfg_r.direction);
      rtc_pkg::REG_ROW_COUNT: prdata = rtc_pkg::APB_DATA_W'(cfg_r.row_count);
      rtc_pkg::REG_COL_COUNT: prdata = rtc_pkg::APB_DATA_W'(cfg_r.col_count);
      rtc_pkg::REG_ROUTE:     prdata = rtc_pkg::APB_DATA_W'(cfg_r.route);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction <= rtc_pkg::DIR_ENCRYPT;
      cfg_r.row_count <= rtc_pkg::REG_W'(MAX_DIM);
      cfg_r.col_count <= rtc_pkg::REG_W'(MAX_DIM);
      cfg_r.route     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Load side: filter, store into the open bank, close the grid on the end item.
  rtc_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .push           (push),
    .char_in        (in_char_in),
    .has_char       (in_has_char),
    .end_of_message (in_end_of_message),
    .full           (full),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in),
    .done           (done)
  );

  // Closed grids wait here for the emitter.
  rtc_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (rtc_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_out_bits),
    .empty (cmd_empty),
    .full  (cmd_full),
    .count (cmd_count)
  );

  assign cmd_out = rtc_pkg::cmd_t'(cmd_out_bits);

  // Emit side: walk the grid and read one cell per cycle while the result queue has room.
  rtc_back #(
    .MAX_DIM   (MAX_DIM),
    .OUT_DEPTH (rtc_pkg::OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .out_count (out_count),
    .out_push  (out_push),
    .out_item  (item_in),
    .done      (done)
  );

  // Result queue decouples pop from the memory read pipeline.
  rtc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (rtc_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (item_in),
    .pop   (pop),
    .rdata (item_out_bits),
    .empty (empty),
    .full  (out_full),
    .count (out_count)
  );

  assign item_out     = rtc_pkg::out_item_t'(item_out_bits);
  assign out_char_out = item_out.ch;
  assign out_last_out = item_out.last;
  assign out_dropped  = item_out.dropped;

`ifndef SYNTHESIS
  // Both banks busy means at least one closed grid still waits in the queue.
  a_full_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (cmd_count != '0))
    else $error("input stalled with no grid waiting");

  // Command queue never overflows.
  a_cmd_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_push && cmd_full))
    else $error("command pushed into full queue");

  // Result queue never overflows.
  a_out_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_push && out_full))
    else $error("result pushed into full queue");
`endif

endmodule

`default_nettype wire
